// ===== src/hnc_pkg.sv =====
`timescale 1ns / 1ps

package hnc_pkg;

    // Result classes
    localparam logic [1:0] CLASS_INVALID = 2'd0;
    localparam logic [1:0] CLASS_IPV4    = 2'd1;
    localparam logic [1:0] CLASS_NAME    = 2'd2;

    // Default limit on the length of a host name in bytes
    localparam int unsigned DEF_MAX_NAME_BYTES = 255;

    // Characters with a role of their own
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_HYPHEN  = 8'h2D;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;

    // Largest value of one dotted-quad group
    localparam logic [9:0] GROUP_MAX = 10'd255;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_decimal(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_decimal(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    endfunction

endpackage

// ===== src/host_name_classifier.sv =====
`timescale 1ns / 1ps

// Host string classifier.
// Input channel (i_valid / o_ready): one byte of a host string per request,
// i_character, with i_last high on the final byte of the string.
// Output channel (o_valid / i_ready): one request per string, o_host_class,
// 0 invalid, 1 dotted-quad IPv4 address, 2 valid host name.
// The last byte of a string is held in the input register, and its class
// is loaded into the result register when that byte is processed, which
// waits while the result register is still full; o_valid rises with that load.
// Throughput: one byte per cycle while results are taken, strings back to
// back with no gap; the parse state is updated in one pass between the
// input register and the result register.
// Reset clears the valid bits of both registers and the parse state;
// o_ready is high in the first cycle after reset.
// When the receiver stalls, bytes that are not last keep flowing through
// the parse logic; a last byte waits in the input register until the
// result register is free, and o_ready stays low while it waits.
module host_name_classifier
    import hnc_pkg::*;
#(
    parameter int unsigned MAX_NAME_BYTES = DEF_MAX_NAME_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_character,
    input  logic       i_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_host_class
);

    localparam int unsigned CntW = $clog2(MAX_NAME_BYTES + 1);

    // Input register
    logic       r_in_vld;
    logic [7:0] r_char;
    logic       r_last;

    // Result register
    logic       r_out_vld;
    logic [1:0] r_class;

    // Parse state
    logic [CntW-1:0] r_byte_count, n_byte_count;
    logic            r_quad_ok, n_quad_ok;
    logic [1:0]      r_quad_dots, n_quad_dots;
    logic [1:0]      r_group_digits, n_group_digits;
    logic [9:0]      r_group_value, n_group_value;
    logic            r_name_ok, n_name_ok;
    logic [2:0]      r_label_len, n_label_len;   // saturates at 4
    logic            r_label_chars_ok, n_label_chars_ok;
    logic            r_label_letters, n_label_letters;
    logic            r_prior_hyphen, n_prior_hyphen;
    logic            r_third_hyphen, n_third_hyphen;
    logic [1:0]      r_hex_pending, n_hex_pending;
    logic [1:0]      n_class;

    logic fire;
    logic hyphen;

    // Process the held byte unless it is last and the result register is full
    assign fire    = r_in_vld && (!r_last || !r_out_vld || i_ready);
    assign o_ready = !r_in_vld || fire;
    assign o_valid = r_out_vld;
    assign o_host_class = r_class;
    assign hyphen  = (r_char == CHAR_HYPHEN);

    // Update the parse state for one byte
    always_comb begin
        n_byte_count     = r_byte_count;
        n_quad_ok        = r_quad_ok;
        n_quad_dots      = r_quad_dots;
        n_group_digits   = r_group_digits;
        n_group_value    = r_group_value;
        n_name_ok        = r_name_ok;
        n_label_len      = r_label_len;
        n_label_chars_ok = r_label_chars_ok;
        n_label_letters  = r_label_letters;
        n_prior_hyphen   = r_prior_hyphen;
        n_third_hyphen   = r_third_hyphen;
        n_hex_pending    = r_hex_pending;

        // Dotted-quad track
        if (is_decimal(r_char)) begin
            if (r_group_digits == 2'd3) begin
                n_quad_ok = 1'b0;
            end else begin
                n_group_value = {r_group_value[6:0], 3'b000}
                              + {r_group_value[8:0], 1'b0}
                              + {6'd0, r_char[3:0]};
                n_group_digits = r_group_digits + 2'd1;
            end
        end else if (r_char == CHAR_DOT) begin
            if (r_group_digits == 2'd0 || r_group_value > GROUP_MAX
                    || r_quad_dots == 2'd3) begin
                n_quad_ok = 1'b0;
            end else begin
                n_quad_dots = r_quad_dots + 2'd1;
            end
            n_group_digits = 2'd0;
            n_group_value  = 10'd0;
        end else begin
            n_quad_ok = 1'b0;
        end

        // Host name length limit
        if (r_byte_count == CntW'(MAX_NAME_BYTES)) begin
            n_name_ok = 1'b0;
        end else begin
            n_byte_count = r_byte_count + CntW'(1);
        end

        // Host name label track
        if (r_char == CHAR_DOT) begin
            if (r_label_len == 3'd0 || !r_label_chars_ok || r_prior_hyphen
                    || r_hex_pending != 2'd0) begin
                n_name_ok = 1'b0;
            end
            n_label_len      = 3'd0;
            n_label_chars_ok = 1'b1;
            n_label_letters  = 1'b1;
            n_prior_hyphen   = 1'b0;
            n_third_hyphen   = 1'b0;
            n_hex_pending    = 2'd0;
        end else begin
            if (r_label_len == 3'd0 && hyphen) begin
                n_label_chars_ok = 1'b0;
            end
            if (r_label_len == 3'd2) begin
                n_third_hyphen = hyphen;
            end
            if (r_label_len == 3'd3 && hyphen && r_third_hyphen) begin
                n_label_chars_ok = 1'b0;
            end
            if (is_letter(r_char) || is_decimal(r_char) || hyphen) begin
                if (r_hex_pending != 2'd0) begin
                    if (is_hex(r_char)) begin
                        n_hex_pending = r_hex_pending - 2'd1;
                    end else begin
                        n_label_chars_ok = 1'b0;
                    end
                end
            end else if (r_char == CHAR_PERCENT && r_hex_pending == 2'd0) begin
                n_hex_pending = 2'd2;
            end else begin
                n_label_chars_ok = 1'b0;
            end
            if (!is_letter(r_char)) begin
                n_label_letters = 1'b0;
            end
            n_prior_hyphen = hyphen;
            if (r_label_len != 3'd4) begin
                n_label_len = r_label_len + 3'd1;
            end
        end

        // Classify the string as it stands after this byte
        if (n_quad_ok && n_quad_dots == 2'd3 && n_group_digits != 2'd0
                && n_group_value <= GROUP_MAX) begin
            n_class = CLASS_IPV4;
        end else if (n_name_ok && (n_label_len == 3'd0 || n_label_letters)) begin
            n_class = CLASS_NAME;
        end else begin
            n_class = CLASS_INVALID;
        end
    end

    // Hold the input request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_char <= i_character;
            r_last <= i_last;
        end
    end

    // Load the result when a last byte is processed, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire && r_last) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_last) begin
            r_class <= n_class;
        end
    end

    // Advance the parse state; restart it after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && r_last)) begin
            r_byte_count     <= '0;
            r_quad_ok        <= 1'b1;
            r_quad_dots      <= 2'd0;
            r_group_digits   <= 2'd0;
            r_group_value    <= 10'd0;
            r_name_ok        <= 1'b1;
            r_label_len      <= 3'd0;
            r_label_chars_ok <= 1'b1;
            r_label_letters  <= 1'b1;
            r_prior_hyphen   <= 1'b0;
            r_third_hyphen   <= 1'b0;
            r_hex_pending    <= 2'd0;
        end else if (fire) begin
            r_byte_count     <= n_byte_count;
            r_quad_ok        <= n_quad_ok;
            r_quad_dots      <= n_quad_dots;
            r_group_digits   <= n_group_digits;
            r_group_value    <= n_group_value;
            r_name_ok        <= n_name_ok;
            r_label_len      <= n_label_len;
            r_label_chars_ok <= n_label_chars_ok;
            r_label_letters  <= n_label_letters;
            r_prior_hyphen   <= n_prior_hyphen;
            r_third_hyphen   <= n_third_hyphen;
            r_hex_pending    <= n_hex_pending;
        end
    end

endmodule

// ===== src/hnc_checker.sv =====
`timescale 1ns / 1ps

module hnc_checker
    import hnc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic [7:0] i_character,
    input logic       i_last,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_host_class
);

    // Hold a waiting byte request
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_character) && $stable(i_last))
        else $error("byte request changed while waiting");

    // Hold a stalled result request
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_host_class))
        else $error("result request changed while stalled");

    // Give only defined classes
    a_class_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_host_class == CLASS_INVALID || o_host_class == CLASS_IPV4
                     || o_host_class == CLASS_NAME))
        else $error("undefined host class");

    // Drop any result and open the input at reset
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("block not idle after reset");

    // A result needs an accepted last byte: none right after an empty cycle
    // of the input register following reset
    a_no_early_result: assert property (@(posedge i_clk)
        !i_rst_n ##1 !(i_valid && o_ready && i_last) |=> !o_valid)
        else $error("result without a last byte");

endmodule

bind host_name_classifier hnc_checker u_hnc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .i_character  (i_character),
    .i_last       (i_last),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_host_class (o_host_class)
);
